@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define IFD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ifd assertion failed");

// expression must never be true outside reset
`define IFD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ifd forbidden condition seen");

`else

`define IFD_ASSERT(lbl, clk, rst_n, prop)
`define IFD_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ rtl/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg
// Types, codes and defaults shared by the forwarding decision block.
// ----------------------------------------------------------------------------
package ifd_pkg;

	localparam int MAX_IFACES_DEF = 4;
	localparam int MAX_ROUTES_DEF = 16;

	localparam logic [15:0] ETH_ARP = 16'h0806;
	localparam logic [15:0] ETH_IP4 = 16'h0800;
	localparam logic [15:0] ETH_IP6 = 16'h86DD;

	localparam logic [15:0] OPC_ARP_REQ = 16'd1;
	localparam logic [15:0] OPC_ARP_RSP = 16'd2;

	localparam logic [7:0] PROTO_ICMP     = 8'd1;
	localparam logic [7:0] PROTO_TCP      = 8'd6;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam logic [7:0] ICMP_ECHO_REQ  = 8'd8;

	typedef enum logic [1:0] {
		ACT_WR_IFACE = 2'd0,
		ACT_WR_ROUTE = 2'd1,
		ACT_CLASSIFY = 2'd2,
		ACT_UNUSED   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		V_WRITTEN  = 4'd0,
		V_DROP     = 4'd1,
		V_REJECT   = 4'd2,
		V_ARP_REPLY = 4'd3,
		V_ARP_LEARN = 4'd4,
		V_HOST_UNR = 4'd5,
		V_PORT_UNR = 4'd6,
		V_TIME_EXC = 4'd7,
		V_ECHO     = 4'd8,
		V_NET_UNR  = 4'd9,
		V_FORWARD  = 4'd10,
		V_LOCAL    = 4'd11
	} verdict_t;

	typedef enum logic [1:0] {
		REG_IFACE_COUNT = 2'd0,
		REG_ROUTE_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_IFW,
		ST_RTW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [31:0] ip_value;
		logic [31:0] mask_value;
		logic [31:0] gateway;
		logic [47:0] mac_value;
		logic [1:0]  port;
		logic [15:0] ethertype;
		logic [15:0] arp_op;
		logic [7:0]  ttl;
		logic [7:0]  proto;
		logic [7:0]  icmp_type;
	} item_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [1:0]  out_port;
		logic [31:0] next_hop;
		logic [7:0]  ttl_out;
	} result_t;

	typedef struct packed {
		logic [1:0] addr;
		logic [4:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} iface_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gw;
		logic [1:0]  port;
	} route_t;

endpackage

@@ rtl/ifd_item_if.sv @@
// ----------------------------------------------------------------------------
// ifd_item_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface ifd_item_if;
	logic          valid;
	logic          ready;
	ifd_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ifd_result_if.sv @@
// ----------------------------------------------------------------------------
// ifd_result_if
// Valid/ready channel carrying one verdict.
// ----------------------------------------------------------------------------
interface ifd_result_if;
	logic            valid;
	logic            ready;
	ifd_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ifd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ifd_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ifd_cfg_if;
	logic         valid;
	logic         ready;
	ifd_pkg::cfg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ipv4_forwarding_decision.sv @@
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision
// Router fast-path verdict engine: interface and route tables in on-chip
// memories, longest-prefix match by walking the route memory.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat
//  item     in   table write or frame to classify (item_t)
//  result   out  one verdict per item (result_t)
//  cfg      in   register write: index 0 iface_count, 1 route_count
//
//  Writes, unused actions and frames other than ARP or IPv4 go straight from
//  accept to the result register. ARP and IPv4 frames walk the interface
//  memory one entry a cycle, and an IPv4 frame for a matching MAC but no local
//  address then walks the route memory, each memory having a single read port.
//  One item in flight; the result register frees the block while a verdict
//  waits. cfg is always ready; reset leaves the tables as they are.
//
module ipv4_forwarding_decision #(
	parameter int MAX_IFACES = ifd_pkg::MAX_IFACES_DEF,
	parameter int MAX_ROUTES = ifd_pkg::MAX_ROUTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ifd_item_if.sink         item,
	ifd_result_if.source     result,
	ifd_cfg_if.sink          cfg
);

	`include "assert_macros.svh"

	localparam int IF_AW  = (MAX_IFACES > 1) ? $clog2(MAX_IFACES) : 1;
	localparam int RT_AW  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int IF_CW  = $clog2(MAX_IFACES + 1);
	localparam int RT_CW  = $clog2(MAX_ROUTES + 1);
	localparam int WALK_W = (IF_CW > RT_CW) ? IF_CW : RT_CW;

	// configuration registers
	logic [2:0] iface_count_q;
	logic [4:0] route_count_q;
	logic [IF_CW-1:0] n_if;
	logic [RT_CW-1:0] n_rt;

	// tables
	ifd_pkg::iface_t if_mem [MAX_IFACES];
	ifd_pkg::route_t rt_mem [MAX_ROUTES];
	ifd_pkg::iface_t if_rd_s1;
	ifd_pkg::route_t rt_rd_s1;

	ifd_pkg::state_t state_q, state_d;
	ifd_pkg::item_t  item_q;
	logic [WALK_W-1:0] cnt_q, idx_s1;
	logic              rdv_s1;

	// interface walk results
	logic       mac_ok_q, ip_hit_q, rx_hit_q;
	logic [1:0] first_port_q;
	// route walk results
	logic        found_q;
	logic [31:0] best_q, nh_q;
	logic [1:0]  bport_q;

	ifd_pkg::result_t res_q, res_d;
	logic             res_valid_q;

	logic item_acc, res_load, if_rd_en, rt_rd_en, if_we, rt_we;
	logic if_walk, rt_walk, if_end, rt_end;
	logic mac_eq, ip_eq, if_acc, rt_hit, mac_ok_d, ip_hit_d;
	logic needs_if_walk, needs_rt_walk;
	logic [31:0] rt_mask;
	logic fwd_load;

	assign n_if = (int'(iface_count_q) > MAX_IFACES) ? IF_CW'(MAX_IFACES)
		: IF_CW'(iface_count_q);
	assign n_rt = (int'(route_count_q) > MAX_ROUTES) ? RT_CW'(MAX_ROUTES)
		: RT_CW'(route_count_q);

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iface_count_q <= 3'd4;
			route_count_q <= 5'd0;
		end else if (cfg.valid) begin
			if (cfg.data.addr == ifd_pkg::REG_IFACE_COUNT)
				iface_count_q <= cfg.data.wdata[2:0];
			else if (cfg.data.addr == ifd_pkg::REG_ROUTE_COUNT)
				route_count_q <= cfg.data.wdata;
		end
	end

	// control decode
	assign item_acc = item.valid && item.ready;
	assign if_walk  = state_q == ifd_pkg::ST_IFW;
	assign rt_walk  = state_q == ifd_pkg::ST_RTW;
	assign if_end   = cnt_q >= WALK_W'(n_if);
	assign rt_end   = cnt_q >= WALK_W'(n_rt);

	assign if_we = item_acc && item.data.action == ifd_pkg::ACT_WR_IFACE
		&& int'(item.data.slot) < MAX_IFACES;
	assign rt_we = item_acc && item.data.action == ifd_pkg::ACT_WR_ROUTE
		&& int'(item.data.slot) < MAX_ROUTES;

	assign needs_if_walk = item.data.action == ifd_pkg::ACT_CLASSIFY
		&& (item.data.ethertype == ifd_pkg::ETH_ARP
		|| item.data.ethertype == ifd_pkg::ETH_IP4);

	// interface entry compare on the registered read data
	assign mac_eq   = if_rd_s1.mac == item_q.mac_value;
	assign ip_eq    = if_rd_s1.ip == item_q.ip_value;
	assign if_acc   = rdv_s1 && if_walk;
	assign mac_ok_d = mac_ok_q || (if_acc && mac_eq);
	assign ip_hit_d = ip_hit_q || (if_acc && ip_eq);
	assign needs_rt_walk = item_q.ethertype == ifd_pkg::ETH_IP4 && mac_ok_d && !ip_hit_d;

	// route entry compare: prefix match, and a mask no shorter than the best
	assign rt_mask = rt_rd_s1.mask;
	assign rt_hit  = rdv_s1 && rt_walk
		&& ((rt_rd_s1.dest & rt_mask) == (item_q.ip_value & rt_mask))
		&& (!found_q || rt_mask >= best_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ifd_pkg::ST_IDLE: begin
				if (item_acc)
					state_d = needs_if_walk ? ifd_pkg::ST_IFW : ifd_pkg::ST_FIN;
			end
			ifd_pkg::ST_IFW: begin
				if (if_end)
					state_d = needs_rt_walk ? ifd_pkg::ST_RTW : ifd_pkg::ST_FIN;
			end
			ifd_pkg::ST_RTW: begin
				if (rt_end)
					state_d = ifd_pkg::ST_FIN;
			end
			ifd_pkg::ST_FIN: begin
				if (res_load)
					state_d = ifd_pkg::ST_IDLE;
			end
			default: state_d = ifd_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready = 1'b0;
		if_rd_en   = 1'b0;
		rt_rd_en   = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ifd_pkg::ST_IDLE: item.ready = 1'b1;
			ifd_pkg::ST_IFW:  if_rd_en = !if_end;
			ifd_pkg::ST_RTW:  rt_rd_en = !rt_end;
			ifd_pkg::ST_FIN:  res_load = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifd_pkg::ST_IDLE;
			cnt_q   <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= if_rd_en || rt_rd_en;
			cnt_q   <= (if_rd_en || rt_rd_en) ? cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// interface memory
	always_ff @(posedge clk) begin
		if (if_we)
			if_mem[IF_AW'(item.data.slot)] <= '{ip: item.data.ip_value,
				mac: item.data.mac_value};
		if (if_rd_en)
			if_rd_s1 <= if_mem[IF_AW'(cnt_q)];
	end

	// route memory
	always_ff @(posedge clk) begin
		if (rt_we)
			rt_mem[RT_AW'(item.data.slot)] <= '{dest: item.data.ip_value,
				mask: item.data.mask_value, gw: item.data.gateway,
				port: item.data.port};
		if (rt_rd_en)
			rt_rd_s1 <= rt_mem[RT_AW'(cnt_q)];
	end

	// captured item
	always_ff @(posedge clk) begin
		if (item_acc)
			item_q <= item.data;
	end

	// walk accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_ok_q <= 1'b0;
			ip_hit_q <= 1'b0;
			rx_hit_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (item_acc) begin
			mac_ok_q <= 1'b0;
			ip_hit_q <= 1'b0;
			rx_hit_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			mac_ok_q <= mac_ok_d;
			ip_hit_q <= ip_hit_d;
			if (if_acc && ip_eq && int'(idx_s1) == int'(item_q.port))
				rx_hit_q <= 1'b1;
			if (rt_hit)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		// lowest matching interface answers an ARP request
		if (if_acc && ip_eq && !ip_hit_q)
			first_port_q <= 2'(idx_s1);
		if (rt_hit) begin
			best_q  <= rt_mask;
			bport_q <= rt_rd_s1.port;
			nh_q    <= (rt_rd_s1.gw != '0) ? rt_rd_s1.gw : item_q.ip_value;
		end
	end

	// verdict
	always_comb begin
		res_d = '{verdict: ifd_pkg::V_REJECT, out_port: '0, next_hop: '0, ttl_out: '0};
		priority if (item_q.action == ifd_pkg::ACT_WR_IFACE
			|| item_q.action == ifd_pkg::ACT_WR_ROUTE) begin
			res_d.verdict = ifd_pkg::V_WRITTEN;
		end else if (item_q.action != ifd_pkg::ACT_CLASSIFY) begin
			res_d.verdict = ifd_pkg::V_REJECT;
		end else if (item_q.ethertype == ifd_pkg::ETH_ARP) begin
			if (item_q.arp_op == ifd_pkg::OPC_ARP_REQ) begin
				if (ip_hit_q) begin
					res_d.verdict  = ifd_pkg::V_ARP_REPLY;
					res_d.out_port = first_port_q;
				end else begin
					res_d.verdict = ifd_pkg::V_HOST_UNR;
				end
			end else if (item_q.arp_op == ifd_pkg::OPC_ARP_RSP) begin
				res_d.verdict = ifd_pkg::V_ARP_LEARN;
			end else begin
				res_d.verdict = ifd_pkg::V_REJECT;
			end
		end else if (item_q.ethertype == ifd_pkg::ETH_IP4) begin
			priority if (!mac_ok_q)
				res_d.verdict = ifd_pkg::V_REJECT;
			else if (ip_hit_q) begin
				priority if (!rx_hit_q)
					res_d.verdict = ifd_pkg::V_HOST_UNR;
				else if (item_q.proto == ifd_pkg::PROTO_TCP
					|| item_q.proto == ifd_pkg::PROTO_UDP)
					res_d.verdict = ifd_pkg::V_PORT_UNR;
				else if (item_q.ttl == 8'd1)
					res_d.verdict = ifd_pkg::V_TIME_EXC;
				else if (item_q.proto == ifd_pkg::PROTO_ICMP
					&& item_q.icmp_type == ifd_pkg::ICMP_ECHO_REQ)
					res_d.verdict = ifd_pkg::V_ECHO;
				else
					res_d.verdict = ifd_pkg::V_LOCAL;
			end else if (!found_q)
				res_d.verdict = ifd_pkg::V_NET_UNR;
			else if (item_q.ttl <= 8'd1)
				res_d.verdict = ifd_pkg::V_TIME_EXC;
			else begin
				res_d.verdict  = ifd_pkg::V_FORWARD;
				res_d.out_port = bport_q;
				res_d.next_hop = nh_q;
				res_d.ttl_out  = item_q.ttl - 8'd1;
			end
		end else if (item_q.ethertype == ifd_pkg::ETH_IP6) begin
			res_d.verdict = ifd_pkg::V_DROP;
		end else begin
			res_d.verdict = ifd_pkg::V_REJECT;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_d;
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// checks
	assign fwd_load = res_load && res_d.verdict == ifd_pkg::V_FORWARD;

	`IFD_ASSERT(a_rt_walk_bound, clk, arst_n, rt_walk |-> cnt_q <= WALK_W'(n_rt))
	`IFD_ASSERT(a_rdata_in_walk, clk, arst_n, rdv_s1 |-> (if_walk || rt_walk))
	`IFD_ASSERT(a_fwd_has_route, clk, arst_n, fwd_load |-> (found_q && res_d.ttl_out != 8'd0))
	`IFD_ASSERT_NEVER(a_write_in_walk, clk, arst_n, (if_we || rt_we) && state_q != ifd_pkg::ST_IDLE)

endmodule
